FILE: hw/rtl/rpo_pkg.sv
// Shared types and constants for the RGBA pixel point operations block.
package rpo_pkg;

    localparam int unsigned CH_W  = 8;
    localparam int unsigned PIX_W = 32;
    localparam int unsigned OFS_W = 9;
    localparam int unsigned IDX_W = 3;
    localparam int unsigned DAT_W = 9;

    localparam logic [CH_W-1:0] CH_MAX = 8'hff;

    // Operation codes held in the mode register.
    localparam logic [2:0] MODE_INVERT = 3'd0;
    localparam logic [2:0] MODE_MONO   = 3'd1;
    localparam logic [2:0] MODE_NIGHT  = 3'd2;
    localparam logic [2:0] MODE_THRESH = 3'd3;
    localparam logic [2:0] MODE_OFFSET = 3'd4;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_MODE         = 3'd0;
    localparam logic [IDX_W-1:0] REG_THRESH_RED   = 3'd1;
    localparam logic [IDX_W-1:0] REG_THRESH_GREEN = 3'd2;
    localparam logic [IDX_W-1:0] REG_THRESH_BLUE  = 3'd3;
    localparam logic [IDX_W-1:0] REG_OFFSET_RED   = 3'd4;
    localparam logic [IDX_W-1:0] REG_OFFSET_GREEN = 3'd5;
    localparam logic [IDX_W-1:0] REG_OFFSET_BLUE  = 3'd6;

    // Divide-by-3 of a channel sum (max 765): (sum * 683) >> 11 is exact below 2048.
    localparam int unsigned    SUM_W      = 10;
    localparam int unsigned    RECIP_W    = 10;
    localparam int unsigned    RECIP_SH   = 11;
    localparam logic [RECIP_W-1:0] RECIP3 = 10'd683;

    typedef struct packed {
        logic [2:0]             mode;
        logic [CH_W-1:0]        thresh_red;
        logic [CH_W-1:0]        thresh_green;
        logic [CH_W-1:0]        thresh_blue;
        logic signed [OFS_W-1:0] offset_red;
        logic signed [OFS_W-1:0] offset_green;
        logic signed [OFS_W-1:0] offset_blue;
    } t_cfg;

endpackage

FILE: hw/rtl/rpo_pixel_op.sv
// Combinational per-pixel datapath: invert, mono, night vision, threshold, offset.
module rpo_pixel_op (
    input  rpo_pkg::t_cfg                 i_cfg,
    input  logic [rpo_pkg::PIX_W-1:0]     i_pixel,
    output logic [rpo_pkg::PIX_W-1:0]     o_pixel
);

    logic [rpo_pkg::CH_W-1:0] red, green, blue, alpha;
    logic [rpo_pkg::CH_W-1:0] red_o, green_o, blue_o;
    logic [rpo_pkg::SUM_W-1:0] sum;
    logic [rpo_pkg::SUM_W+rpo_pkg::RECIP_W-1:0] prod;
    logic [rpo_pkg::CH_W-1:0] avg;

    // Offset add with clamp to 0..255; 10-bit signed covers -256..510.
    function automatic logic [rpo_pkg::CH_W-1:0] add_sat(
        input logic [rpo_pkg::CH_W-1:0]          c,
        input logic signed [rpo_pkg::OFS_W-1:0]  ofs
    );
        logic signed [rpo_pkg::CH_W+1:0] v;
        v = $signed({2'b00, c}) + $signed({ofs[rpo_pkg::OFS_W-1], ofs});
        if (v[rpo_pkg::CH_W+1]) begin
            add_sat = '0;
        end else if (v[rpo_pkg::CH_W]) begin
            add_sat = rpo_pkg::CH_MAX;
        end else begin
            add_sat = v[rpo_pkg::CH_W-1:0];
        end
    endfunction

    assign red   = i_pixel[31:24];
    assign green = i_pixel[23:16];
    assign blue  = i_pixel[15:8];
    assign alpha = i_pixel[7:0];

    assign sum  = {2'b00, red} + {2'b00, green} + {2'b00, blue};
    assign prod = sum * rpo_pkg::RECIP3;
    assign avg  = prod[rpo_pkg::RECIP_SH +: rpo_pkg::CH_W];

    always_comb begin
        red_o   = red;
        green_o = green;
        blue_o  = blue;
        case (i_cfg.mode)
            rpo_pkg::MODE_INVERT: begin
                red_o   = rpo_pkg::CH_MAX - red;
                green_o = rpo_pkg::CH_MAX - green;
                blue_o  = rpo_pkg::CH_MAX - blue;
            end
            rpo_pkg::MODE_MONO: begin
                red_o   = avg;
                green_o = avg;
                blue_o  = avg;
            end
            rpo_pkg::MODE_NIGHT: begin
                red_o   = '0;
                green_o = avg;
                blue_o  = '0;
            end
            rpo_pkg::MODE_THRESH: begin
                red_o   = (red   >= i_cfg.thresh_red)   ? red   : '0;
                green_o = (green >= i_cfg.thresh_green) ? green : '0;
                blue_o  = (blue  >= i_cfg.thresh_blue)  ? blue  : '0;
            end
            rpo_pkg::MODE_OFFSET: begin
                red_o   = add_sat(red,   i_cfg.offset_red);
                green_o = add_sat(green, i_cfg.offset_green);
                blue_o  = add_sat(blue,  i_cfg.offset_blue);
            end
            default: begin
                // unused codes pass the pixel through
                red_o   = red;
                green_o = green;
                blue_o  = blue;
            end
        endcase
    end

    assign o_pixel = {red_o, green_o, blue_o, alpha};

endmodule

FILE: hw/rtl/rgba_pixel_point_ops.sv
// Top level of the RGBA pixel point operations block: handshakes, config, pipeline.
//
// One RGBA8888 pixel (red in bits 31..24, alpha in 7..0) goes in per request and one
// processed pixel comes out, alpha copied unchanged. The mode register selects invert,
// monochrome, night vision, per-channel threshold, or signed per-channel offset with
// saturation (equal offsets give a brightness change); mode codes 5..7 pass the pixel
// through. The block is a two-register pipeline: an input register, then one pass of
// short logic (an adder tree, a small constant multiply for the divide by three, and
// per-channel compares/adds) into the result register. It sustains one pixel per
// clock with no bubbles as long as the sink keeps i_out_ready high. A stalled sink
// holds the full result register and, once it fills, the input register; backpressure
// reaches o_in_ready in the same cycle. Config writes are always accepted (o_cfg_ready
// is tied high); indexes past the register list are dropped. Change the config only
// while no pixel is in flight.
module rgba_pixel_point_ops (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rpo_pkg::PIX_W-1:0]     i_pixel_in,
    // pixel output
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rpo_pkg::PIX_W-1:0]     o_pixel_out,
    // config write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rpo_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [rpo_pkg::DAT_W-1:0]     i_cfg_data
);

    rpo_pkg::t_cfg r_cfg, n_cfg;

    logic                         r_s1_valid;
    logic [rpo_pkg::PIX_W-1:0]    r_s1_pixel;
    logic                         r_out_valid;
    logic [rpo_pkg::PIX_W-1:0]    r_out_pixel;

    logic                         out_load;
    logic                         s1_load;
    logic [rpo_pkg::PIX_W-1:0]    op_pixel;

    // Config register file
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                rpo_pkg::REG_MODE:         n_cfg.mode         = i_cfg_data[2:0];
                rpo_pkg::REG_THRESH_RED:   n_cfg.thresh_red   = i_cfg_data[7:0];
                rpo_pkg::REG_THRESH_GREEN: n_cfg.thresh_green = i_cfg_data[7:0];
                rpo_pkg::REG_THRESH_BLUE:  n_cfg.thresh_blue  = i_cfg_data[7:0];
                rpo_pkg::REG_OFFSET_RED:   n_cfg.offset_red   = $signed(i_cfg_data);
                rpo_pkg::REG_OFFSET_GREEN: n_cfg.offset_green = $signed(i_cfg_data);
                rpo_pkg::REG_OFFSET_BLUE:  n_cfg.offset_blue  = $signed(i_cfg_data);
                default: begin
                    // no register at this index: drop the write
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Pipeline control: result register loads when empty or being drained,
    // input register loads when empty or moving forward.
    assign out_load   = !r_out_valid || i_out_ready;
    assign s1_load    = !r_s1_valid || out_load;
    assign o_in_ready = s1_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && i_in_valid) begin
            r_s1_pixel <= i_pixel_in;
        end
        if (out_load && r_s1_valid) begin
            r_out_pixel <= op_pixel;
        end
    end

    rpo_pixel_op u_pixel_op (
        .i_cfg   (r_cfg),
        .i_pixel (r_s1_pixel),
        .o_pixel (op_pixel)
    );

    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_out_pixel;

endmodule

FILE: verif/tb.sv
// Self-checking testbench for rgba_pixel_point_ops: directed table, random phases, scoreboard.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CH_W  = rpo_pkg::CH_W;
    localparam int PIX_W = rpo_pkg::PIX_W;
    localparam int OFS_W = rpo_pkg::OFS_W;
    localparam int IDX_W = rpo_pkg::IDX_W;
    localparam int DAT_W = rpo_pkg::DAT_W;

    // Seven registers exist; index 7 lies past the list and must be dropped.
    localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

    localparam int RAND_ITEMS   = 750;
    localparam int LIMIT_CYCLES = 200000;
    localparam int N_STEPS      = 35;

    // Sink behavior, re-chosen at random when the sink countdown runs out.
    typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SLOW} t_sink_style;

    // One row of the directed script: either a register write or a pixel request.
    // A pixel row either carries a hand-computed result or leaves it to the predictor.
    typedef struct {
        bit               is_write;
        logic [IDX_W-1:0] idx;
        logic [DAT_W-1:0] data;
        logic [PIX_W-1:0] pix;
        bit               typed;
        logic [PIX_W-1:0] want;
    } t_step;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic [PIX_W-1:0]   i_pixel_in  = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [PIX_W-1:0]   o_pixel_out;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [IDX_W-1:0]   i_cfg_index = '0;
    logic [DAT_W-1:0]   i_cfg_data  = '0;

    rgba_pixel_point_ops dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_pixel_in  (i_pixel_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pixel_out (o_pixel_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mirror of the register file, updated when a write handshake completes.
    rpo_pkg::t_cfg    regs_mirror = '0;
    // Expected output pixels, oldest first, queued as each request is issued.
    logic [PIX_W-1:0] pending_pixels[$];
    logic [PIX_W-1:0] exp_pix;

    int n_errors  = 0;
    int n_checked = 0;
    int n_sent    = 0;
    int n_writes  = 0;
    int cycles    = 0;
    int burst_left = 1;

    t_sink_style sink_style = SINK_OPEN;
    int          sink_left  = 0;

    // Channel plus signed offset, clamped to 0..255.
    function automatic logic [CH_W-1:0] sat_add(input logic [CH_W-1:0] c,
                                                 input logic signed [OFS_W-1:0] ofs);
        int v;
        v = int'(c) + int'(ofs);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[CH_W-1:0];
    endfunction

    // Predicted output pixel for the current register settings.
    function automatic logic [PIX_W-1:0] point_op(input logic [PIX_W-1:0] pix);
        logic [CH_W-1:0] r, g, b, a, avg;
        int unsigned     sum;
        r   = pix[31:24];
        g   = pix[23:16];
        b   = pix[15:8];
        a   = pix[7:0];
        sum = int'(r) + int'(g) + int'(b);
        avg = CH_W'(sum / 3);
        case (regs_mirror.mode)
            rpo_pkg::MODE_INVERT: begin
                r = rpo_pkg::CH_MAX - r;
                g = rpo_pkg::CH_MAX - g;
                b = rpo_pkg::CH_MAX - b;
            end
            rpo_pkg::MODE_MONO: begin
                r = avg;
                g = avg;
                b = avg;
            end
            rpo_pkg::MODE_NIGHT: begin
                r = '0;
                g = avg;
                b = '0;
            end
            rpo_pkg::MODE_THRESH: begin
                if (r < regs_mirror.thresh_red)   r = '0;
                if (g < regs_mirror.thresh_green) g = '0;
                if (b < regs_mirror.thresh_blue)  b = '0;
            end
            rpo_pkg::MODE_OFFSET: begin
                r = sat_add(r, regs_mirror.offset_red);
                g = sat_add(g, regs_mirror.offset_green);
                b = sat_add(b, regs_mirror.offset_blue);
            end
            default: ; // codes 5..7 leave the pixel as it came
        endcase
        return {r, g, b, a};
    endfunction

    function automatic t_step wr_row(input logic [IDX_W-1:0] idx, input logic [DAT_W-1:0] data);
        return '{1'b1, idx, data, '0, 1'b0, '0};
    endfunction

    function automatic t_step px_row(input logic [PIX_W-1:0] pix);
        return '{1'b0, '0, '0, pix, 1'b0, '0};
    endfunction

    function automatic t_step chk_row(input logic [PIX_W-1:0] pix, input logic [PIX_W-1:0] want);
        return '{1'b0, '0, '0, pix, 1'b1, want};
    endfunction

    // Stop issuing and wait at falling edges until every queued pixel has come back.
    task automatic drain_pixels();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_pixels.size() != 0);
        @(posedge i_clk);
    endtask

    // Register write, only ever issued with the pipeline empty.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DAT_W-1:0] data);
        drain_pixels();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_writes++;
        case (idx)
            rpo_pkg::REG_MODE:         regs_mirror.mode         = data[2:0];
            rpo_pkg::REG_THRESH_RED:   regs_mirror.thresh_red   = data[CH_W-1:0];
            rpo_pkg::REG_THRESH_GREEN: regs_mirror.thresh_green = data[CH_W-1:0];
            rpo_pkg::REG_THRESH_BLUE:  regs_mirror.thresh_blue  = data[CH_W-1:0];
            rpo_pkg::REG_OFFSET_RED:   regs_mirror.offset_red   = data;
            rpo_pkg::REG_OFFSET_GREEN: regs_mirror.offset_green = data;
            rpo_pkg::REG_OFFSET_BLUE:  regs_mirror.offset_blue  = data;
            default: ; // past the list: dropped
        endcase
    endtask

    // Issue one pixel request and hold it until accepted. Bursts end with a random gap;
    // valid stays high between back-to-back requests.
    task automatic issue_pixel(input logic [PIX_W-1:0] pix, input bit typed,
                               input logic [PIX_W-1:0] want);
        pending_pixels.push_back(typed ? want : point_op(pix));
        i_in_valid <= 1'b1;
        i_pixel_in <= pix;
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            // mostly short bursts, now and then a long unbroken run
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // Channel values biased toward the edges and the threshold boundary.
    function automatic logic [CH_W-1:0] pick_channel(input logic [CH_W-1:0] thr);
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return rpo_pkg::CH_MAX;
            2:       return thr;
            3:       return thr - 1'b1;
            default: return CH_W'($urandom);
        endcase
    endfunction

    function automatic logic [DAT_W-1:0] pick_offset();
        case ($urandom_range(0, 7))
            0:       return 9'h0ff; // +255
            1:       return 9'h100; // -256, clamps everything
            2:       return 9'h101; // -255
            3:       return 9'h000;
            4:       return 9'h001;
            5:       return 9'h1ff; // -1
            default: return DAT_W'($urandom);
        endcase
    endfunction

    function automatic logic [DAT_W-1:0] pick_thresh();
        case ($urandom_range(0, 3))
            0:       return 9'h000;
            1:       return 9'h0ff;
            default: return DAT_W'($urandom); // upper bit is don't-care
        endcase
    endfunction

    // New random register set for one phase; every write waits for an empty pipeline.
    task automatic shuffle_regs();
        logic [DAT_W-1:0] bright;
        logic [DAT_W-1:0] mode_data;
        if ($urandom_range(0, 1) == 1) begin
            write_reg(rpo_pkg::REG_THRESH_RED,   pick_thresh());
            write_reg(rpo_pkg::REG_THRESH_GREEN, pick_thresh());
            write_reg(rpo_pkg::REG_THRESH_BLUE,  pick_thresh());
        end
        if ($urandom_range(0, 2) == 0) begin
            // brightness: one offset for all three channels
            bright = pick_offset();
            write_reg(rpo_pkg::REG_OFFSET_RED,   bright);
            write_reg(rpo_pkg::REG_OFFSET_GREEN, bright);
            write_reg(rpo_pkg::REG_OFFSET_BLUE,  bright);
        end else if ($urandom_range(0, 1) == 1) begin
            write_reg(rpo_pkg::REG_OFFSET_RED,   pick_offset());
            write_reg(rpo_pkg::REG_OFFSET_GREEN, pick_offset());
            write_reg(rpo_pkg::REG_OFFSET_BLUE,  pick_offset());
        end
        if ($urandom_range(0, 7) == 0)
            write_reg(REG_NONE, DAT_W'($urandom));
        // favor the two modes that use the other registers; unused codes now and then
        case ($urandom_range(0, 9))
            8:       mode_data = {6'(0), rpo_pkg::MODE_THRESH};
            9:       mode_data = {6'(0), rpo_pkg::MODE_OFFSET};
            default: mode_data = DAT_W'($urandom);
        endcase
        write_reg(rpo_pkg::REG_MODE, mode_data);
    endtask

    // Sink: stalls follow a style that is re-chosen at random when its countdown runs out.
    always @(posedge i_clk) begin
        if (sink_left == 0) begin
            sink_style <= t_sink_style'($urandom_range(0, 2));
            sink_left  <= $urandom_range(20, 80);
        end else begin
            sink_left <= sink_left - 1;
        end
        case (sink_style)
            SINK_OPEN: i_out_ready <= 1'b1;
            SINK_COIN: i_out_ready <= 1'($urandom_range(0, 1));
            default:   i_out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Scoreboard: each returned pixel against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel_out: no request pending, got %h", o_pixel_out);
                n_errors++;
            end else begin
                exp_pix = pending_pixels.pop_front();
                if (o_pixel_out !== exp_pix) begin
                    $error("pixel_out: expected %h, got %h", exp_pix, o_pixel_out);
                    n_errors++;
                end
                n_checked++;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_pixels.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus: reset, directed script, then random phases.
    initial begin
        t_step script [N_STEPS];
        int    rand_sent;
        int    phase_len;
        int    k;
        logic [PIX_W-1:0] pix;

        script = '{
            // reset value of mode is invert
            chk_row(32'h0000_0000, 32'hffff_ff00),
            chk_row(32'hffff_ffff, 32'h0000_00ff),
            chk_row(32'h1234_5678, 32'hedcb_a978),
            wr_row(rpo_pkg::REG_MODE, {6'(0), rpo_pkg::MODE_MONO}),
            chk_row(32'hffff_ffff, 32'hffff_ffff),   // largest sum, 765/3
            chk_row(32'h0100_00c3, 32'h0000_00c3),   // average truncates to zero
            px_row(32'h1234_5600),
            px_row(32'h0202_0181),
            wr_row(rpo_pkg::REG_MODE, {6'(0), rpo_pkg::MODE_NIGHT}),
            chk_row(32'hffff_ff11, 32'h00ff_0011),
            px_row(32'h9a3c_7e55),
            wr_row(rpo_pkg::REG_THRESH_RED,   9'h080),
            wr_row(rpo_pkg::REG_THRESH_GREEN, 9'h0ff),
            wr_row(rpo_pkg::REG_THRESH_BLUE,  9'h000),
            wr_row(rpo_pkg::REG_MODE, {6'(0), rpo_pkg::MODE_THRESH}),
            chk_row(32'h7fff_0033, 32'h00ff_0033),   // one below / equal / zero threshold
            chk_row(32'h80fe_40aa, 32'h8000_40aa),
            wr_row(rpo_pkg::REG_OFFSET_RED,   9'h0ff),        // +255
            wr_row(rpo_pkg::REG_OFFSET_GREEN, 9'h100),        // -256
            wr_row(rpo_pkg::REG_OFFSET_BLUE,  9'h101),        // -255
            wr_row(rpo_pkg::REG_MODE, {6'(0), rpo_pkg::MODE_OFFSET}),
            chk_row(32'h01ff_ff5a, 32'hff00_005a),
            chk_row(32'h0000_0077, 32'hff00_0077),
            wr_row(rpo_pkg::REG_OFFSET_RED,   9'h1f0),        // brightness -16
            wr_row(rpo_pkg::REG_OFFSET_GREEN, 9'h1f0),
            wr_row(rpo_pkg::REG_OFFSET_BLUE,  9'h1f0),
            px_row(32'h0810_ff3c),
            px_row(32'hc0c0_c0c0),
            wr_row(rpo_pkg::REG_MODE, 9'd5),                  // unused codes pass through
            chk_row(32'hdead_beef, 32'hdead_beef),
            wr_row(rpo_pkg::REG_MODE, 9'h1ff),                // upper data bits dropped: code 7
            chk_row(32'h0bad_f00d, 32'h0bad_f00d),
            wr_row(rpo_pkg::REG_MODE, 9'h1fe),                // code 6
            wr_row(REG_NONE, 9'h1ff),                         // index past the list, ignored
            chk_row(32'h5a5a_a5a5, 32'h5a5a_a5a5)
        };

        // hold the synchronous reset, then release it
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            if (script[i].is_write)
                write_reg(script[i].idx, script[i].data);
            else
                issue_pixel(script[i].pix, script[i].typed, script[i].want);
        end

        // Random phases: fresh registers, then a run of pixels under them.
        rand_sent = 0;
        while (rand_sent < RAND_ITEMS) begin
            shuffle_regs();
            phase_len = $urandom_range(20, 80);
            for (k = 0; k < phase_len && rand_sent < RAND_ITEMS; k++) begin
                // occasional full stop mid-phase until every result is back
                if ($urandom_range(0, 99) == 0)
                    drain_pixels();
                if ($urandom_range(0, 4) == 0) begin
                    pix = $urandom;
                end else begin
                    pix = {pick_channel(regs_mirror.thresh_red),
                           pick_channel(regs_mirror.thresh_green),
                           pick_channel(regs_mirror.thresh_blue),
                           CH_W'($urandom)};
                end
                issue_pixel(pix, 1'b0, '0);
                rand_sent++;
            end
        end

        drain_pixels();
        // keep clocking to catch any stray output before the summary
        repeat (10) @(posedge i_clk);

        $display("%0d pixel requests, %0d results compared, %0d register writes",
                 n_sent, n_checked, n_writes);
        $display("modes 0..7, threshold edges, offset saturation both ways, ignored index");
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d errors", n_errors);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: rgba_pixel_point_ops.f
hw/rtl/rpo_pkg.sv
hw/rtl/rpo_pixel_op.sv
hw/rtl/rgba_pixel_point_ops.sv
verif/tb.sv
